// ===== src/hrle_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the hybrid run-length row decoder.
// No dependencies; imported by hrle_core and hybrid_rle_row_decoder.
package hrle_pkg;

    localparam int X_W      = 10;
    localparam int COL_W    = 11;
    localparam int BYTE_W   = 8;
    localparam int WIDTH_W  = 11;
    localparam int RUN_W    = 8;

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_REPEAT  = 2'd1;
    localparam logic [1:0] MODE_LITERAL = 2'd2;

    localparam int HDR_LITERAL_BIT = 7;

    localparam logic [WIDTH_W-1:0] SCENE_WIDTH_RESET = 11'd144;
    localparam logic [COL_W-1:0]   COL_DEAD          = 11'd1024;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              row_start;
        logic [X_W-1:0]    row_min_x;
        logic [X_W-1:0]    row_max_x;
        logic              row_last_byte;
    } code_item_t;

    typedef struct packed {
        logic [X_W-1:0]    span_x;
        logic [RUN_W-1:0]  span_length;
        logic [BYTE_W-1:0] pixel_index;
    } span_item_t;

    typedef struct packed {
        logic       emit;
        span_item_t span;
    } core_res_t;

endpackage

// ===== src/hybrid_rle_row_decoder.sv =====
`timescale 1ns / 1ps
// Each code beat is registered in in_reg, and any span it emits in out_reg.
// Throughput: one code beat per cycle when not stalled; the core updates all state in one pass.
// A waiting span only blocks input once the input register is also full.
// Reset (rst_n, async, active low) empties both registers, sets the decoder
// to expect a header at column 0 with clip 0, and scene_width to 144.
module hybrid_rle_row_decoder #(
    parameter int MAX_ROW_BYTES = 320
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [hrle_pkg::WIDTH_W-1:0]  cfg_wr_data,
    input  logic                          code_valid,
    output logic                          code_stall,
    input  hrle_pkg::code_item_t          code_data,
    output logic                          span_valid,
    input  logic                          span_stall,
    output hrle_pkg::span_item_t          span_data
);
    import hrle_pkg::*;

    logic [WIDTH_W-1:0] scene_width_reg;
    logic               in_valid_reg, in_valid_next;
    code_item_t         in_reg;
    logic               out_valid_reg, out_valid_next;
    span_item_t         out_reg;
    logic               out_open;
    logic               consume;
    logic               take_in;
    core_res_t          core_res;

    assign out_open   = !out_valid_reg || !span_stall;
    assign consume    = in_valid_reg && out_open;
    assign code_stall = in_valid_reg && !out_open;
    assign take_in    = code_valid && !code_stall;

    assign span_valid = out_valid_reg;
    assign span_data  = out_reg;

    hrle_core #(
        .MAX_ROW_BYTES(MAX_ROW_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (consume),
        .code       (in_reg),
        .scene_width(scene_width_reg),
        .result     (core_res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take_in)
        begin
            in_valid_next = 1'b1;
        end
        else if (consume)
        begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (out_open)
        begin
            out_valid_next = consume && core_res.emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scene_width_reg <= SCENE_WIDTH_RESET;
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                scene_width_reg <= cfg_wr_data;
            end
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            in_reg <= code_data;
        end
        if (consume && core_res.emit)
        begin
            out_reg <= core_res.span;
        end
    end

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        code_stall |-> in_valid_reg && out_valid_reg)
        else $error("input stalled with nothing held");

    a_span_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> (span_data.span_length != 8'd0) && (span_data.span_length <= 8'd128))
        else $error("span length out of range");

    a_span_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        span_valid |-> ({1'b0, span_data.span_x} + {3'b000, span_data.span_length}) <= 11'd1024)
        else $error("span runs past last column");
`endif

endmodule

// ===== src/hrle_core.sv =====
`timescale 1ns / 1ps
// Decode state and single-pass next-state logic for one code beat.
// Depends on hrle_pkg.
module hrle_core #(
    parameter int MAX_ROW_BYTES = 320
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       fire,
    input  hrle_pkg::code_item_t       code,
    input  logic [hrle_pkg::WIDTH_W-1:0] scene_width,
    output hrle_pkg::core_res_t        result
);
    import hrle_pkg::*;

    localparam int SEEN_W = $clog2(MAX_ROW_BYTES + 1);
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(MAX_ROW_BYTES);

    logic [1:0]        mode_reg,  mode_next;
    logic [RUN_W-1:0]  run_reg,   run_next;
    logic [COL_W-1:0]  col_reg,   col_next;
    logic [X_W-1:0]    clip_reg,  clip_next;
    logic [SEEN_W-1:0] seen_reg,  seen_next;

    logic [1:0]         mode_eff;
    logic [RUN_W-1:0]   run_eff;
    logic [COL_W-1:0]   col_eff;
    logic [X_W-1:0]     clip_eff;
    logic [SEEN_W-1:0]  seen_eff;
    logic [WIDTH_W-1:0] w1;
    logic [COL_W-1:0]   room;
    logic [RUN_W-1:0]   rep_len;
    logic [RUN_W-1:0]   run_dec;
    logic               take;

    always_comb
    begin
        mode_eff = mode_reg;
        run_eff  = run_reg;
        col_eff  = col_reg;
        clip_eff = clip_reg;
        seen_eff = seen_reg;
        w1       = scene_width - WIDTH_W'(1);
        if (code.row_start)
        begin
            mode_eff = MODE_HEADER;
            run_eff  = '0;
            seen_eff = '0;
            if (scene_width == '0)
            begin
                clip_eff = '0;
                col_eff  = COL_DEAD;
            end
            else
            begin
                clip_eff = ({1'b0, code.row_max_x} < w1) ? code.row_max_x : w1[X_W-1:0];
                col_eff  = {1'b0, code.row_min_x};
            end
        end

        take    = (seen_eff < SEEN_MAX) && (col_eff <= {1'b0, clip_eff});
        room    = {1'b0, clip_eff} - col_eff + COL_W'(1);
        rep_len = ({3'b000, run_eff} < room) ? run_eff : room[RUN_W-1:0];
        run_dec = (run_eff != '0) ? run_eff - RUN_W'(1) : run_eff;

        mode_next = mode_eff;
        run_next  = run_eff;
        col_next  = col_eff;
        clip_next = clip_eff;
        seen_next = (seen_eff < SEEN_MAX) ? seen_eff + SEEN_W'(1) : seen_eff;
        if (code.row_last_byte)
        begin
            seen_next = SEEN_MAX;
        end

        result.emit             = 1'b0;
        result.span.span_x      = col_eff[X_W-1:0];
        result.span.span_length = rep_len;
        result.span.pixel_index = code.code_byte;

        if (take)
        begin
            unique case (mode_eff)
                MODE_REPEAT:
                begin
                    result.emit = 1'b1;
                    col_next    = col_eff + {3'b000, rep_len};
                    run_next    = '0;
                    mode_next   = MODE_HEADER;
                end
                MODE_LITERAL:
                begin
                    result.emit             = 1'b1;
                    result.span.span_length = RUN_W'(1);
                    col_next                = col_eff + COL_W'(1);
                    run_next                = run_dec;
                    if (run_dec == '0)
                    begin
                        mode_next = MODE_HEADER;
                    end
                end
                default:
                begin
                    run_next  = {1'b0, code.code_byte[6:0]} + RUN_W'(1);
                    mode_next = code.code_byte[HDR_LITERAL_BIT] ? MODE_LITERAL : MODE_REPEAT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_HEADER;
            run_reg  <= '0;
            col_reg  <= '0;
            clip_reg <= '0;
            seen_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg <= mode_next;
            run_reg  <= run_next;
            col_reg  <= col_next;
            clip_reg <= clip_next;
            seen_reg <= seen_next;
        end
    end

`ifndef SYNTHESIS
    a_no_emit_on_header: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.emit |-> !code.row_start && (mode_reg != MODE_HEADER))
        else $error("span emitted from header state");

    a_literal_len_one: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.emit && (mode_reg == MODE_LITERAL) |-> result.span.span_length == 8'd1)
        else $error("literal span longer than one");

    a_seen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seen_reg <= SEEN_MAX && col_reg <= COL_DEAD)
        else $error("byte count or column out of range");
`endif

endmodule
